// File: hdl/chm_pkg.sv
// Shared types and constants for the chained hash map.
package chm_pkg;

   localparam int KEY_W = 31;
   localparam int VAL_W = 31;
   localparam int ACT_W = 2;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

   // Bucket index reduction: reciprocal width, one bit above the key
   localparam int RECIP_W = KEY_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_WALK,
      ST_ALLOC,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

// File: hdl/chm_ifs.sv
// Request and response channel interfaces of the chained hash map.
interface chm_req_if;
   logic                     valid;
   logic                     ready;
   logic [chm_pkg::ACT_W-1:0] action;
   logic [chm_pkg::KEY_W-1:0] key;
   logic [chm_pkg::VAL_W-1:0] value;
   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

interface chm_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [chm_pkg::VAL_W-1:0] read_value;
   logic                     full_res;
   modport source (output valid, found, read_value, full_res, input ready);
   modport sink   (input valid, found, read_value, full_res, output ready);
endinterface

// File: hdl/chained_hash_map_top.sv
// Chained hash map: bucket heads in flops, node pool and free stack in RAMs.
// Steps from request transfer: hash, head lookup, walk of k chain nodes (one per cycle
// through the node RAM read port), done; a put that takes a new node adds an alloc step,
// and a link step when it links behind a tail node. Unused action code goes to done.
// Bucket index: mod unit key, product and remainder registers. One action in flight;
// next request taken the cycle after the response loads. Reset: heads empty, free count = NODES.
module chained_hash_map_top #(
   parameter int BUCKETS = 31,
   parameter int NODES   = 256
) (
   input  logic         clock,
   input  logic         reset,
   chm_req_if.sink      req,
   chm_rsp_if.source    rsp
);
   import chm_pkg::*;

   localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int PW = $clog2(NODES + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = KEY_W + VAL_W + PW;
   localparam logic [PW-1:0] NIL = PW'(NODES);

   state_type        state_ff, state_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [BW-1:0]    bucket_ff, bucket_in;
   logic [PW-1:0]    cur_ff, cur_in;
   logic [PW-1:0]    last_ff, last_in;
   logic [KEY_W-1:0] last_key_ff, last_key_in;
   logic [VAL_W-1:0] last_val_ff, last_val_in;
   logic [PW-1:0]    steps_ff, steps_in;
   logic [IW-1:0]    new_node_ff, new_node_in;
   logic [PW-1:0]    free_count_ff, free_count_in;
   logic [PW-1:0]    free_low_ff, free_low_in;
   logic             found_ff, found_in;
   logic             full_ff, full_in;
   logic [VAL_W-1:0] rv_ff, rv_in;
   logic [PW-1:0]    head_ff [BUCKETS];
   logic             head_we;
   logic [PW-1:0]    head_wdata;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_full_ff, rsp_full_in;

   logic             hash_start, hash_done;
   logic [BW-1:0]    hash_bucket;

   logic             node_we;
   logic [IW-1:0]    node_waddr, node_raddr;
   logic [NW-1:0]    node_wdata, node_rdata;
   logic [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0] rd_val;
   logic [PW-1:0]    rd_next;

   logic             free_we;
   logic [IW-1:0]    free_waddr, free_raddr;
   logic [IW-1:0]    free_wdata, free_rdata;
   logic [PW-1:0]    free_pos;
   logic [PW-1:0]    head_val;
   logic [PW-1:0]    steps_nx;
   logic             req_xfer;

   chm_mod_unit #(.BUCKETS(BUCKETS)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key_in (req.key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   chm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_waddr),
      .wr_data (free_wdata),
      .rd_addr (free_raddr),
      .rd_data (free_rdata)
   );

   assign rd_key   = node_rdata[NW-1 -: KEY_W];
   assign rd_val   = node_rdata[PW +: VAL_W];
   assign rd_next  = node_rdata[PW-1:0];
   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign hash_start = req_xfer && (req.action <= ACT_REMOVE);
   assign head_val   = head_ff[bucket_ff];
   assign steps_nx   = steps_ff + 1'b1;

   // Free stack top; held for the whole action, so read data is ready on a miss
   assign free_pos   = free_count_ff - 1'b1;
   assign free_raddr = free_pos[IW-1:0];

   // Control: hash, walk the chain, then update node/free/head storage
   always_comb begin
      logic          miss;
      logic [IW-1:0] n;
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      last_key_in   = last_key_ff;
      last_val_in   = last_val_ff;
      steps_in      = steps_ff;
      new_node_in   = new_node_ff;
      free_count_in = free_count_ff;
      free_low_in   = free_low_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      rv_in         = rv_ff;
      head_we       = 1'b0;
      head_wdata    = NIL;
      node_we       = 1'b0;
      node_waddr    = cur_ff[IW-1:0];
      node_wdata    = {key_ff, val_ff, rd_next};
      node_raddr    = cur_ff[IW-1:0];
      free_we       = 1'b0;
      free_waddr    = free_count_ff[IW-1:0];
      free_wdata    = cur_ff[IW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_full_in   = rsp_full_ff;
      miss          = 1'b0;
      n             = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               act_in   = req.action;
               key_in   = req.key;
               val_in   = req.value;
               found_in = 1'b0;
               full_in  = 1'b0;
               rv_in    = '0;
               state_in = (req.action <= ACT_REMOVE) ? ST_HASH : ST_DONE;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            last_in  = NIL;
            steps_in = '0;
            cur_in   = head_val;
            if (head_val >= NIL) begin
               miss = 1'b1;
            end else begin
               node_raddr = head_val[IW-1:0];
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rd_key == key_ff) begin
               // Hit on the current node
               found_in = 1'b1;
               state_in = ST_DONE;
               case (act_ff)
                  ACT_PUT: begin
                     node_we = 1'b1;
                  end
                  ACT_GET: begin
                     rv_in = rd_val;
                  end
                  default: begin
                     if (last_ff < NIL) begin
                        node_we    = 1'b1;
                        node_waddr = last_ff[IW-1:0];
                        node_wdata = {last_key_ff, last_val_ff, rd_next};
                     end else begin
                        head_we    = 1'b1;
                        head_wdata = rd_next;
                     end
                     if (free_count_ff < NIL) begin
                        free_we       = 1'b1;
                        free_count_in = free_count_ff + 1'b1;
                     end
                  end
               endcase
            end else begin
               last_in     = cur_ff;
               last_key_in = rd_key;
               last_val_in = rd_val;
               steps_in    = steps_nx;
               cur_in      = rd_next;
               node_raddr  = rd_next[IW-1:0];
               if (rd_next >= NIL || steps_nx == NIL) begin
                  miss = 1'b1;
               end
            end
         end
         ST_ALLOC: begin
            // Pop a free node; unwritten slots below the low-water mark give n from free_pos
            if (free_pos < free_low_ff) begin
               n = IW'(NODES - 1) - free_pos[IW-1:0];
            end else begin
               n = free_rdata;
            end
            new_node_in   = n;
            free_count_in = free_pos;
            if (free_pos < free_low_ff) begin
               free_low_in = free_pos;
            end
            node_we    = 1'b1;
            node_waddr = n;
            node_wdata = {key_ff, val_ff, NIL};
            if (last_ff < NIL) begin
               state_in = ST_LINK;
            end else begin
               head_we    = 1'b1;
               head_wdata = PW'(n);
               state_in   = ST_DONE;
            end
         end
         ST_LINK: begin
            node_we    = 1'b1;
            node_waddr = last_ff[IW-1:0];
            node_wdata = {last_key_ff, last_val_ff, PW'(new_node_ff)};
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_value_in = rv_ff;
               rsp_full_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Key absent: a put takes a node or reports full, others finish
      if (miss) begin
         if (act_ff == ACT_PUT) begin
            if (free_count_ff == '0) begin
               full_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_ALLOC;
            end
         end else begin
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= NIL;
         free_low_ff   <= NIL;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) begin
            head_ff[i] <= NIL;
         end
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         free_low_ff   <= free_low_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (head_we) begin
            head_ff[bucket_ff] <= head_wdata;
         end
      end
      act_ff       <= act_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      bucket_ff    <= bucket_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      last_key_ff  <= last_key_in;
      last_val_ff  <= last_val_in;
      steps_ff     <= steps_in;
      new_node_ff  <= new_node_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      rv_ff        <= rv_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.read_value = rsp_value_ff;
   assign rsp.full_res   = rsp_full_ff;
endmodule

// File: hdl/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/chm_mod_unit.sv
// Key mod BUCKETS reduction by reciprocal multiplication, pipelined through key, product and remainder registers.
module chm_mod_unit #(
   parameter int BUCKETS = 31
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [chm_pkg::KEY_W-1:0]                   key_in,
   output logic                                        done,
   output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);
   import chm_pkg::*;

   localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LG  = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
   localparam int SH  = KEY_W + LG;
   localparam int PRW = KEY_W + RECIP_W;
   // Rounded-up reciprocal; exact quotient for every key of KEY_W bits
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   logic [KEY_W-1:0] hkey_ff, hkey_in;
   logic [PRW-1:0]   prod_ff, prod_in;
   logic [BW-1:0]    rem_ff, rem_in;
   logic             stage1_ff, stage1_in;
   logic             stage2_ff, stage2_in;
   logic             done_ff, done_in;
   logic [KEY_W-1:0] quot;
   logic [KEY_W-1:0] quot_mul;

   // Key capture, quotient product, then remainder
   always_comb begin
      hkey_in   = start ? key_in : hkey_ff;
      stage1_in = start;
      prod_in   = {{RECIP_W{1'b0}}, hkey_ff} * {{KEY_W{1'b0}}, RECIP};
      stage2_in = stage1_ff;
      quot      = KEY_W'(prod_ff >> SH);
      quot_mul  = KEY_W'(quot * KEY_W'(BUCKETS));
      rem_in    = BW'(hkey_ff - quot_mul);
      done_in   = stage2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= stage1_in;
         stage2_ff <= stage2_in;
         done_ff   <= done_in;
      end
      hkey_ff <= hkey_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;
endmodule

// File: hdl/chm_checker.sv
// Port-level checker for the chained hash map, bound to the top level.
module chm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [chm_pkg::VAL_W-1:0]  rsp_read_value,
   input logic                       rsp_full_res
);
   // Response held until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Stalled response payload stays put
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_read_value)
                                 && $stable(rsp_full_res))
      else $error("response payload changed while stalled");

   // A dropped put never reports a present key
   a_full_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> !rsp_found)
      else $error("full flagged on a hit");

   // A nonzero value only comes from a hit
   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0) |-> rsp_found)
      else $error("value returned without a hit");

   // One action at a time: busy right after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an action is in flight");
endmodule

bind chained_hash_map_top chm_checker u_chm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_found      (rsp.found),
   .rsp_read_value (rsp.read_value),
   .rsp_full_res   (rsp.full_res)
);
